>>> hw/rtl/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg
// shared sizes, codes and a pointer helper for the ordered list core
// ----------------------------------------------------------------------------
package olpd_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = CNT_W + 1;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] stat_t;

  // request modes
  localparam mode_t MODE_INS_FRONT = 2'd0;
  localparam mode_t MODE_INS_BACK  = 2'd1;
  localparam mode_t MODE_DELETE    = 2'd2;
  localparam mode_t MODE_READ_ALL  = 2'd3;

  // result status codes
  localparam stat_t STAT_OK        = 2'd0;
  localparam stat_t STAT_EMPTY     = 2'd1;
  localparam stat_t STAT_NOT_FOUND = 2'd2;
  localparam stat_t STAT_FULL      = 2'd3;

  // ring pointer plus offset, offset at most CAPACITY
  function automatic idx_t idx_add(idx_t a, cnt_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return idx_t'(s);
  endfunction

endpackage

>>> hw/rtl/ordered_list_with_positional_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_with_positional_delete_core
// bounded ordered list of signed 32-bit values kept as a ring in one ram
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i/in_ready_o  | mode_i, value_i, position_i
//  out     | output    | out_valid_o/out_ready_i| item_value_o, status_o, last_o
//
//  insert, refused requests, and deletes of the front or back entry give one
//  beat; an interior delete at position p moves each later entry down one
//  slot, one per cycle, each write overlapping the read of the next entry
//  read-out gives one beat per cycle while out_ready_i holds
//  reset clears state, head, count, idx and out valid; no clearing pass over ram
//  a stalled output holds the list walk; input is taken only when the
//  sequencer is idle and the output register is free or draining
//
module ordered_list_with_positional_delete_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic signed [31:0] value_i,
  input  logic [4:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] item_value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]                        state_q, state_d;
  olpd_pkg::idx_t                    head_q, head_d;
  olpd_pkg::cnt_t                    count_q, count_d;
  // list index whose read data is due from the ram
  olpd_pkg::cnt_t                    idx_q, idx_d;

  logic                              out_valid_q, out_valid_d;
  logic [olpd_pkg::VAL_W-1:0]        item_value_q, item_value_d;
  olpd_pkg::stat_t                   status_q, status_d;
  logic                              last_q, last_d;

  // ram port
  logic                              ram_we, ram_re;
  olpd_pkg::idx_t                    ram_waddr, ram_raddr;
  logic [olpd_pkg::VAL_W-1:0]        ram_wdata, ram_rdata;

  logic                              slot_free;
  logic                              in_fire;
  olpd_pkg::cmp_t                    pos_c, count_c;
  olpd_pkg::idx_t                    head_dec;
  olpd_pkg::cnt_t                    count_m1;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_c      = olpd_pkg::cmp_t'(position_i);
  assign count_c    = olpd_pkg::cmp_t'(count_q);
  assign count_m1   = count_q - olpd_pkg::cnt_t'(1);
  assign head_dec   = (head_q == '0) ? olpd_pkg::idx_t'(olpd_pkg::CAPACITY - 1)
                                     : head_q - olpd_pkg::idx_t'(1);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    item_value_d = item_value_q;
    status_d     = status_q;
    last_d       = last_q;
    ram_we       = 1'b0;
    ram_waddr    = head_q;
    ram_wdata    = value_i;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // default result: one status beat, zero value
          out_valid_d  = 1'b1;
          item_value_d = '0;
          status_d     = olpd_pkg::STAT_OK;
          last_d       = 1'b1;
          unique case (mode_i)
            olpd_pkg::MODE_INS_FRONT,
            olpd_pkg::MODE_INS_BACK: begin
              if (count_q >= olpd_pkg::cnt_t'(olpd_pkg::CAPACITY)) begin
                status_d = olpd_pkg::STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + olpd_pkg::cnt_t'(1);
                if (mode_i == olpd_pkg::MODE_INS_FRONT) begin
                  ram_waddr = head_dec;
                  head_d    = head_dec;
                end else begin
                  ram_waddr = olpd_pkg::idx_add(head_q, count_q);
                end
              end
            end
            olpd_pkg::MODE_DELETE: begin
              priority if (count_q == '0) begin
                status_d = olpd_pkg::STAT_EMPTY;
              end else if (pos_c == '0 || pos_c > count_c) begin
                status_d = olpd_pkg::STAT_NOT_FOUND;
              end else if (pos_c == count_c) begin
                // back entry goes, tail moves up by one
                count_d = count_m1;
              end else if (pos_c == olpd_pkg::cmp_t'(1)) begin
                // front entry goes, head steps forward
                head_d  = olpd_pkg::idx_add(head_q, olpd_pkg::cnt_t'(1));
                count_d = count_m1;
              end else begin
                // interior entry: close the gap one slot per cycle
                out_valid_d = 1'b0;
                idx_d       = olpd_pkg::cnt_t'(position_i);
                ram_re      = 1'b1;
                ram_raddr   = olpd_pkg::idx_add(head_q, olpd_pkg::cnt_t'(position_i));
                state_d     = S_SHIFT;
              end
            end
            olpd_pkg::MODE_READ_ALL: begin
              if (count_q == '0) begin
                status_d = olpd_pkg::STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                idx_d       = '0;
                ram_re      = 1'b1;
                ram_raddr   = head_q;
                state_d     = S_READ;
              end
            end
            default: begin
              status_d = olpd_pkg::STAT_OK;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // entry idx_q arrives, moves down to idx_q - 1
        ram_we    = 1'b1;
        ram_waddr = olpd_pkg::idx_add(head_q, idx_q - olpd_pkg::cnt_t'(1));
        ram_wdata = ram_rdata;
        if (idx_q == count_m1) begin
          count_d      = count_m1;
          out_valid_d  = 1'b1;
          item_value_d = '0;
          status_d     = olpd_pkg::STAT_OK;
          last_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = olpd_pkg::idx_add(head_q, idx_q + olpd_pkg::cnt_t'(1));
          idx_d     = idx_q + olpd_pkg::cnt_t'(1);
        end
      end

      S_READ: begin
        // ram data holds until the next read, so a stall just waits here
        if (slot_free) begin
          out_valid_d  = 1'b1;
          item_value_d = ram_rdata;
          status_d     = olpd_pkg::STAT_OK;
          last_d       = (idx_q == count_m1);
          if (idx_q == count_m1) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = olpd_pkg::idx_add(head_q, idx_q + olpd_pkg::cnt_t'(1));
            idx_d     = idx_q + olpd_pkg::cnt_t'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    item_value_q <= item_value_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  olpd_ram #(
    .WIDTH (olpd_pkg::VAL_W),
    .DEPTH (olpd_pkg::CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign item_value_o = item_value_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  // count never runs past the store size
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olpd_pkg::cnt_t'(olpd_pkg::CAPACITY))
    else $error("entry count above capacity");

  // a shift only runs on an interior entry of a list of two or more
  a_shift_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> (count_q >= olpd_pkg::cnt_t'(2)) && (idx_q < count_q)
                           && (idx_q != '0))
    else $error("shift index out of range");

  // read-out never writes the ram
  a_read_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !ram_we)
    else $error("ram write during read-out");

  // leaving a walk always delivers a final beat
  a_walk_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && (state_d == S_IDLE) |=> out_valid_q && last_q)
    else $error("walk ended without a last beat");

endmodule

>>> hw/rtl/olpd_ram.sv
// ----------------------------------------------------------------------------
// olpd_ram
// generic one write, one read port ram with registered read data
// ----------------------------------------------------------------------------
module olpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
